### rtl/lstb_pkg.sv
// ----------------------------------------------------------------------------
// lstb_pkg: shared types and constants of the link state tracker
// Level and event codes, field widths, reset values and result packing.
// ----------------------------------------------------------------------------
package lstb_pkg;

    localparam int BO_W     = 19;   // backoff and its registers
    localparam int JP_W     = 6;    // jitter percent
    localparam int PROD_W   = BO_W + JP_W;
    localparam int RND_W    = 32;   // random word, divider dividend
    localparam int DEN_W    = BO_W + 1; // divisor: 100 or twice the jitter
    localparam int LVL_W    = 3;
    localparam int MODE_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    localparam logic [BO_W-1:0] RESET_MIN    = BO_W'(5000);
    localparam logic [BO_W-1:0] RESET_MAX    = BO_W'(300000);
    localparam logic [JP_W-1:0] RESET_JITTER = JP_W'(25);
    localparam int              PCT_BASE     = 100;

    typedef enum logic [LVL_W-1:0] {
        LVL_NO_LINK     = 3'd0,
        LVL_NO_UPSTREAM = 3'd1,
        LVL_UNREG       = 3'd2,
        LVL_CONNECTING  = 3'd3,
        LVL_ONLINE      = 3'd4
    } t_level;

    typedef enum logic [MODE_W-1:0] {
        EV_LINK_UP      = 3'd0,
        EV_LINK_DOWN    = 3'd1,
        EV_SESSION_UP   = 3'd2,
        EV_SESSION_DOWN = 3'd3,
        EV_REG_CHANGE   = 3'd4,
        EV_CHECK        = 3'd5
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BACKOFF_MIN = 2'd0,
        CFG_BACKOFF_MAX = 2'd1,
        CFG_JITTER_PCT  = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        ST_IDLE,
        ST_GROW
    } t_top_state;

    typedef enum logic [1:0] {
        BO_IDLE,
        BO_MUL,
        BO_SCALE,
        BO_JITTER
    } t_bo_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_bo_stat;

    function automatic logic [OUT_DATA_W-1:0] pack_result(
        input logic [LVL_W-1:0] old_lvl,
        input logic [LVL_W-1:0] new_lvl,
        input logic [BO_W-1:0]  backoff
    );
        logic up, upstream, online, chg;
        up       = (new_lvl >= LVL_NO_UPSTREAM);
        upstream = (new_lvl >= LVL_UNREG);
        online   = (new_lvl == LVL_ONLINE);
        chg      = (new_lvl != old_lvl);
        return {3'b000, backoff, online, upstream, up, chg, new_lvl, old_lvl};
    endfunction

endpackage

### rtl/lstb_div.sv
// ----------------------------------------------------------------------------
// lstb_div: bit-serial restoring divider
// One quotient bit per cycle, dividend shifted out from the top.
// ----------------------------------------------------------------------------
module lstb_div
    import lstb_pkg::*;
#(
    parameter int DIVIDEND_W = RND_W,
    parameter int DIVISOR_W  = DEN_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient,
    output logic [DIVISOR_W-1:0]  o_remainder
);

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_q;
    logic [DIVISOR_W:0]    r_rem;
    logic [DIVISOR_W-1:0]  r_den;

    logic [DIVISOR_W:0]    w_trial;
    logic                  w_ge;

    always_comb begin
        w_trial = {r_rem[DIVISOR_W-1:0], r_q[DIVIDEND_W-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
            r_cnt <= CNT_W'(DIVIDEND_W - 1);
        end else if (r_busy) begin
            r_q   <= {r_q[DIVIDEND_W-2:0], w_ge};
            r_rem <= w_ge ? (w_trial - {1'b0, r_den}) : w_trial;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem[DIVISOR_W-1:0];

endmodule

### rtl/lstb_backoff.sv
// ----------------------------------------------------------------------------
// lstb_backoff: backoff growth sequencer
// Doubles and clamps the backoff, scales it by the jitter percent with a
// serial multiply, then divides by 100 and draws the jitter remainder.
// ----------------------------------------------------------------------------
module lstb_backoff
    import lstb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [BO_W-1:0]  i_cur,
    input  logic [BO_W-1:0]  i_bmax,
    input  logic [JP_W-1:0]  i_jitter,
    input  logic [RND_W-1:0] i_rnd,
    output t_bo_stat         o_stat,
    output logic [BO_W-1:0]  o_backoff
);

    localparam int MUL_CNT_W = $clog2(JP_W);

    t_bo_state              r_state, n_state;
    logic                   r_done;
    logic [BO_W-1:0]        r_b;
    logic [BO_W-1:0]        r_j;
    logic [BO_W-1:0]        r_res;
    logic [PROD_W-1:0]      r_acc;
    logic [JP_W-1:0]        r_jp;
    logic [MUL_CNT_W-1:0]   r_cnt;
    logic [RND_W-1:0]       r_rnd;

    logic [PROD_W-1:0]      n_acc;
    logic [BO_W:0]          w_dbl;
    logic [BO_W-1:0]        w_clamped;
    logic                   w_div_start;
    logic [RND_W-1:0]       w_div_num;
    logic [DEN_W-1:0]       w_div_den;
    logic                   w_div_done;
    logic [RND_W-1:0]       w_div_q;
    logic [DEN_W-1:0]       w_div_r;
    logic [BO_W-1:0]        w_j;
    logic [BO_W+1:0]        w_sum;
    logic [BO_W-1:0]        w_sat;

    always_comb begin
        w_dbl     = {i_cur, 1'b0};
        w_clamped = (w_dbl > {1'b0, i_bmax}) ? i_bmax : w_dbl[BO_W-1:0];
        n_acc     = {r_acc[PROD_W-2:0], 1'b0}
                  + (r_jp[JP_W-1] ? PROD_W'(r_b) : PROD_W'(0));
        w_j       = w_div_q[BO_W-1:0];
        w_sum     = {2'b00, r_b} - {2'b00, r_j} + {1'b0, w_div_r};
        w_sat     = (w_sum[BO_W+1:BO_W] != 2'b00) ? '1 : w_sum[BO_W-1:0];
    end

    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        w_div_num   = RND_W'(n_acc);
        w_div_den   = DEN_W'(PCT_BASE);
        case (r_state)
            BO_IDLE: begin
                if (i_start) begin
                    n_state = BO_MUL;
                end
            end
            BO_MUL: begin
                if (r_cnt == '0) begin
                    w_div_start = 1'b1;
                    n_state     = BO_SCALE;
                end
            end
            BO_SCALE: begin
                if (w_div_done) begin
                    if (w_j == '0) begin
                        n_state = BO_IDLE;
                    end else begin
                        w_div_start = 1'b1;
                        w_div_num   = r_rnd;
                        w_div_den   = {w_j, 1'b0};
                        n_state     = BO_JITTER;
                    end
                end
            end
            BO_JITTER: begin
                if (w_div_done) begin
                    n_state = BO_IDLE;
                end
            end
            default: begin
                n_state = BO_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BO_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= ((r_state == BO_SCALE) || (r_state == BO_JITTER))
                       && (n_state == BO_IDLE);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BO_IDLE: begin
                r_b   <= w_clamped;
                r_acc <= '0;
                r_jp  <= i_jitter;
                r_rnd <= i_rnd;
                r_cnt <= MUL_CNT_W'(JP_W - 1);
            end
            BO_MUL: begin
                r_acc <= n_acc;
                r_jp  <= {r_jp[JP_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
            end
            BO_SCALE: begin
                r_j   <= w_j;
                r_res <= r_b;
            end
            BO_JITTER: begin
                r_res <= w_sat;
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    lstb_div #(
        .DIVIDEND_W (RND_W),
        .DIVISOR_W  (DEN_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_div_num),
        .i_divisor   (w_div_den),
        .o_done      (w_div_done),
        .o_quotient  (w_div_q),
        .o_remainder (w_div_r)
    );

    assign o_stat.busy = (r_state != BO_IDLE);
    assign o_stat.done = r_done;
    assign o_backoff   = r_res;

endmodule

### rtl/link_state_tracker_with_backoff.sv
// ----------------------------------------------------------------------------
// link_state_tracker_with_backoff: five-level link state with retry backoff
// Tracks no link / no upstream / unregistered / connecting / online and a
// retry backoff that doubles with jitter on session loss.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one event per beat: tuser is the event kind, tdata holds
//   registered, check_ok and the random word. m_axis returns one result beat
//   per event with the old and new level, the status flags and the backoff.
//   The cfg channel writes backoff_min, backoff_max and jitter_percent; it
//   is always ready and is to be written only while no event is in flight.
//   Most events pass from acceptance through the holding stage and the
//   output stage to m_axis. A session down at connecting or online runs
//   the backoff sequencer: 6 multiply steps and two 32-step serial
//   divisions; with zero jitter the second division is skipped. The
//   serial divider takes one quotient bit per cycle. An event is taken
//   only while no backoff is growing and the holding stage is empty; a
//   result beat waits in a holding stage and an output stage, so one more
//   event is taken while the receiver stalls.
//   Reset: level goes to no link, backoff and registers to their defaults.
// ----------------------------------------------------------------------------
module link_state_tracker_with_backoff
    import lstb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // registered, check_ok, random_word[31:0], pad
    input  logic [MODE_W-1:0]     s_axis_tuser,  // mode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // old_level, new_level, changed, link_up,
                                                 // upstream_up, is_online, backoff_now, pad
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [BO_W-1:0]       i_cfg_data
);

    t_top_state              r_state;
    logic [LVL_W-1:0]        r_level, n_level;
    logic [BO_W-1:0]         r_backoff, n_backoff;
    logic [LVL_W-1:0]        r_old;
    logic [BO_W-1:0]         r_bmin;
    logic [BO_W-1:0]         r_bmax;
    logic [JP_W-1:0]         r_jitter;
    logic                    r_hold_valid;
    logic [OUT_DATA_W-1:0]   r_hold_data;
    logic                    r_out_valid;
    logic [OUT_DATA_W-1:0]   r_out_data;

    logic                    w_accept;
    logic                    w_grow;
    logic                    w_move;
    logic                    w_reg;
    logic                    w_ok;
    logic [RND_W-1:0]        w_rnd;
    t_bo_stat                w_bo;
    logic [BO_W-1:0]         w_bo_res;

    assign w_reg = s_axis_tdata[0];
    assign w_ok  = s_axis_tdata[1];
    assign w_rnd = s_axis_tdata[RND_W+1:2];

    assign s_axis_tready = (r_state == ST_IDLE) && !r_hold_valid;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_move        = r_hold_valid && (!r_out_valid || m_axis_tready);
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        n_level   = r_level;
        n_backoff = r_backoff;
        w_grow    = 1'b0;
        case (s_axis_tuser)
            EV_LINK_UP: begin
                n_level = LVL_NO_UPSTREAM;
            end
            EV_LINK_DOWN: begin
                n_level   = LVL_NO_LINK;
                n_backoff = r_bmin;
            end
            EV_SESSION_UP: begin
                n_level   = LVL_ONLINE;
                n_backoff = r_bmin;
            end
            EV_SESSION_DOWN: begin
                if (r_level >= LVL_CONNECTING) begin
                    n_level = w_reg ? LVL_CONNECTING : LVL_UNREG;
                    w_grow  = 1'b1;
                end
            end
            EV_REG_CHANGE: begin
                if (r_level == LVL_UNREG && w_reg) begin
                    n_level = LVL_CONNECTING;
                end else if (r_level >= LVL_CONNECTING && !w_reg) begin
                    n_level = LVL_UNREG;
                end
            end
            EV_CHECK: begin
                if (w_ok) begin
                    if (r_level == LVL_NO_UPSTREAM) begin
                        n_level = w_reg ? LVL_CONNECTING : LVL_UNREG;
                    end
                end else if (r_level > LVL_NO_UPSTREAM) begin
                    n_level = LVL_NO_UPSTREAM;
                end
            end
            default: begin
                n_level = r_level;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_level      <= LVL_NO_LINK;
            r_backoff    <= RESET_MIN;
            r_bmin       <= RESET_MIN;
            r_bmax       <= RESET_MAX;
            r_jitter     <= RESET_JITTER;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BACKOFF_MIN: r_bmin   <= i_cfg_data;
                    CFG_BACKOFF_MAX: r_bmax   <= i_cfg_data;
                    CFG_JITTER_PCT:  r_jitter <= i_cfg_data[JP_W-1:0];
                    default:         r_bmin   <= r_bmin;
                endcase
            end

            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_move) begin
                        r_hold_valid <= 1'b0;
                    end
                    if (w_accept) begin
                        r_level   <= n_level;
                        r_backoff <= n_backoff;
                        if (w_grow) begin
                            r_state <= ST_GROW;
                        end else begin
                            r_hold_valid <= 1'b1;
                        end
                    end
                end
                ST_GROW: begin
                    if (w_move) begin
                        r_hold_valid <= 1'b0;
                    end
                    if (w_bo.done) begin
                        r_backoff    <= w_bo_res;
                        r_hold_valid <= 1'b1;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_data <= r_hold_data;
        end
        if (w_accept) begin
            r_old       <= r_level;
            r_hold_data <= pack_result(r_level, n_level, n_backoff);
        end else if (r_state == ST_GROW && w_bo.done) begin
            r_hold_data <= pack_result(r_old, r_level, w_bo_res);
        end
    end

    lstb_backoff u_backoff (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept && w_grow),
        .i_cur     (r_backoff),
        .i_bmax    (r_bmax),
        .i_jitter  (r_jitter),
        .i_rnd     (w_rnd),
        .o_stat    (w_bo),
        .o_backoff (w_bo_res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_seq_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!w_bo.busy && !w_bo.done))
        else $error("backoff sequencer active while tracker idle");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LVL_ONLINE)
        else $error("level out of range");

    a_link_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tuser == EV_LINK_DOWN)
        |=> (r_level == LVL_NO_LINK && r_backoff == $past(r_bmin)))
        else $error("link down did not restore level and backoff");

    a_online_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[9] == (m_axis_tdata[5:3] == LVL_ONLINE)))
        else $error("online flag disagrees with new level");

endmodule
